// ----- hw/rtl/dsd_pkg.sv -----
package dsd_pkg;

    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_HEADER  = 3'd1,
        PH_INSTR   = 3'd2,
        PH_NEWDATA = 3'd3,
        PH_DONE    = 3'd4,
        PH_ERROR   = 3'd5
    } t_phase;

    localparam logic [2:0] KIND_HEADER = 3'd0;
    localparam logic [2:0] KIND_INSTR  = 3'd1;
    localparam logic [2:0] KIND_DATA   = 3'd2;
    localparam logic [2:0] KIND_END    = 3'd3;
    localparam logic [2:0] KIND_ERROR  = 3'd4;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_MAGIC      = 3'd1;
    localparam logic [2:0] ERR_HEADER     = 3'd2;
    localparam logic [2:0] ERR_BACKWARD   = 3'd3;
    localparam logic [2:0] ERR_INSTR      = 3'd4;
    localparam logic [2:0] ERR_TARGET     = 3'd5;
    localparam logic [2:0] ERR_EARLY_END  = 3'd6;

    localparam logic [1:0] ACT_SRC_COPY = 2'd0;
    localparam logic [1:0] ACT_TGT_COPY = 2'd1;
    localparam logic [1:0] ACT_NEW_DATA = 2'd2;
    localparam logic [1:0] ACT_INVALID  = 2'd3;

    localparam logic [1:0] MAGIC_LAST = 2'd3;

    typedef struct packed {
        logic       is_end;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [1:0]  action;
        logic [31:0] op_length;
        logic [31:0] op_offset;
        logic [7:0]  data_out;
        logic [31:0] src_view_offset;
        logic [31:0] src_view_length;
        logic [31:0] tgt_view_length;
        logic [31:0] instr_section_length;
        logic [31:0] new_section_length;
        logic [2:0]  error_code;
        logic        window_end;
    } t_rec;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = 8'h53;
            2'd1:    b = 8'h56;
            2'd2:    b = 8'h4E;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- hw/rtl/dsd_if.sv -----
interface dsd_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] in_byte;

    modport source (output valid, output func, output in_byte, input ready);
    modport sink   (input valid, input func, input in_byte, output ready);
endinterface

interface dsd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  record_kind;
    logic [1:0]  action;
    logic [31:0] op_length;
    logic [31:0] op_offset;
    logic [7:0]  data_out;
    logic [31:0] src_view_offset;
    logic [31:0] src_view_length;
    logic [31:0] tgt_view_length;
    logic [31:0] instr_section_length;
    logic [31:0] new_section_length;
    logic [2:0]  error_code;
    logic        window_end;

    modport source (
        output valid, output record_kind, output action, output op_length,
        output op_offset, output data_out, output src_view_offset,
        output src_view_length, output tgt_view_length,
        output instr_section_length, output new_section_length,
        output error_code, output window_end, input ready
    );
    modport sink (
        input valid, input record_kind, input action, input op_length,
        input op_offset, input data_out, input src_view_offset,
        input src_view_length, input tgt_view_length,
        input instr_section_length, input new_section_length,
        input error_code, input window_end, output ready
    );
endinterface

// ----- hw/rtl/dsd_front.sv -----
module dsd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dsd_in_if.sink         i_in,
    input  logic           i_pop,
    output logic           o_q_valid,
    output dsd_pkg::t_item o_q_item
);
    import dsd_pkg::*;

    t_item      r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic       push, pop;

    assign i_in.ready = (r_count != 2'd2);
    assign push       = i_in.valid && i_in.ready;
    assign pop        = i_pop && (r_count != 2'd0);
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_item   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= '{is_end: i_in.func, data: i_in.in_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) r_wptr <= ~r_wptr;
            if (pop)  r_rptr <= ~r_rptr;
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ----- hw/rtl/dsd_back.sv -----
module dsd_back #(
    parameter int VB = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  dsd_pkg::t_item i_q_item,
    output logic           o_pop,
    dsd_out_if.source      o_out
);
    import dsd_pkg::*;

    function automatic logic [31:0] lo32(input logic [VB-1:0] x);
        logic [VB+31:0] t;
        t = {32'b0, x};
        return t[31:0];
    endfunction

    t_phase        r_phase, n_phase;
    logic [1:0]    r_mcnt, n_mcnt;
    logic [2:0]    r_field, n_field;
    logic [VB-1:0] r_acc, n_acc;
    logic          r_first, n_first;
    logic [VB-1:0] r_voff, n_voff, r_vlen, n_vlen, r_tlen, n_tlen;
    logic [VB-1:0] r_irem, n_irem, r_ndlen, n_ndlen, r_ndrem, n_ndrem;
    logic [VB-1:0] r_tpos, n_tpos, r_pvoff, n_pvoff, r_pvlen, n_pvlen;
    logic          r_stage, n_stage;
    logic [1:0]    r_pact, n_pact;
    logic [VB-1:0] r_plen, n_plen;

    logic          r_ovalid;
    t_rec          r_rec, s_rec;

    logic          s_emit, s_wend;
    logic [2:0]    s_kind, s_err;
    logic [1:0]    s_act;
    logic [VB-1:0] s_v;

    logic [7:0]    b;
    logic          five, cont, ovf;
    logic [VB-1:0] v;
    logic [VB:0]   sum_new, sum_prev, sum_src, sum_nd;
    logic [VB-1:0] irem_dec, ndrem_dec, tpos_sum, room;

    assign b     = i_q_item.data;
    assign o_pop = i_q_valid && (!r_ovalid || o_out.ready);

    // varint digit: 5 data bits in the first byte of an instruction length
    always_comb begin
        five = (r_phase == PH_INSTR) && !r_stage;
        ovf  = 1'b0;
        if (r_first) begin
            v    = five ? {{(VB-5){1'b0}}, b[4:0]} : {{(VB-7){1'b0}}, b[6:0]};
            cont = five ? b[5] : b[7];
        end else begin
            ovf  = |(r_acc >> (VB - 7));
            v    = {r_acc[VB-8:0], b[6:0]};
            cont = b[7];
        end
    end

    always_comb begin
        sum_new   = {1'b0, r_voff} + {1'b0, r_vlen};
        sum_prev  = {1'b0, r_pvoff} + {1'b0, r_pvlen};
        sum_src   = {1'b0, v} + {1'b0, r_plen};
        sum_nd    = sum_src;
        irem_dec  = r_irem - {{(VB-1){1'b0}}, 1'b1};
        ndrem_dec = r_ndrem - {{(VB-1){1'b0}}, 1'b1};
        tpos_sum  = r_tpos + r_plen;
        room      = r_tlen - r_tpos;
    end

    // next state and record selection for one transaction
    always_comb begin
        n_phase = r_phase; n_mcnt = r_mcnt; n_field = r_field; n_acc = r_acc;
        n_first = r_first; n_voff = r_voff; n_vlen = r_vlen; n_tlen = r_tlen;
        n_irem = r_irem; n_ndlen = r_ndlen; n_ndrem = r_ndrem; n_tpos = r_tpos;
        n_pvoff = r_pvoff; n_pvlen = r_pvlen; n_stage = r_stage;
        n_pact = r_pact; n_plen = r_plen;
        s_emit = 1'b0; s_kind = KIND_ERROR; s_err = ERR_NONE; s_wend = 1'b0;
        s_act = r_pact; s_v = v;

        if (r_phase == PH_DONE || r_phase == PH_ERROR) begin
            // drop
        end else if (i_q_item.is_end) begin
            s_emit = 1'b1;
            if (r_phase == PH_HEADER && r_field == 3'd0 && r_first) begin
                n_phase = PH_DONE;
                s_kind  = KIND_END;
            end else begin
                n_phase = PH_ERROR;
                s_err   = ERR_EARLY_END;
            end
        end else begin
            unique case (r_phase)
                PH_MAGIC: begin
                    if (b != magic_byte(r_mcnt)) begin
                        n_phase = PH_ERROR; s_emit = 1'b1; s_err = ERR_MAGIC;
                    end else begin
                        n_mcnt = r_mcnt + 2'd1;
                        if (r_mcnt == MAGIC_LAST) n_phase = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    if (ovf) begin
                        n_phase = PH_ERROR; s_emit = 1'b1; s_err = ERR_HEADER;
                    end else begin
                        n_acc   = v;
                        n_first = !cont;
                        if (!cont) begin
                            n_field = r_field + 3'd1;
                            unique case (r_field)
                                3'd0:    n_voff = v;
                                3'd1:    n_vlen = v;
                                3'd2:    n_tlen = v;
                                3'd3:    n_irem = v;
                                default: n_ndlen = v;
                            endcase
                            if (r_field == 3'd4) begin
                                n_field = 3'd0;
                                s_emit  = 1'b1;
                                if (r_voff < r_pvoff || sum_new < sum_prev) begin
                                    n_phase = PH_ERROR; s_err = ERR_BACKWARD;
                                end else if (r_irem == '0 && r_tlen != '0) begin
                                    n_phase = PH_ERROR; s_err = ERR_TARGET;
                                end else begin
                                    s_kind  = KIND_HEADER;
                                    n_pvoff = r_voff;
                                    n_pvlen = r_vlen;
                                    n_tpos  = '0;
                                    n_stage = 1'b0;
                                    n_ndrem = v;
                                    if (r_irem != '0)   n_phase = PH_INSTR;
                                    else if (v != '0)   n_phase = PH_NEWDATA;
                                    else                s_wend  = 1'b1;
                                end
                            end
                        end
                    end
                end
                PH_INSTR: begin
                    n_irem = irem_dec;
                    if (!r_stage && r_first && b[7:6] == ACT_INVALID) begin
                        n_phase = PH_ERROR; s_emit = 1'b1; s_err = ERR_INSTR;
                    end else if (ovf) begin
                        n_phase = PH_ERROR; s_emit = 1'b1; s_err = ERR_INSTR;
                    end else begin
                        if (!r_stage && r_first) n_pact = b[7:6];
                        n_acc   = v;
                        n_first = !cont;
                        if (cont || !r_stage) begin
                            if (!cont) begin
                                n_plen  = v;
                                n_stage = 1'b1;
                            end
                            if (irem_dec == '0) begin
                                n_phase = PH_ERROR; s_emit = 1'b1; s_err = ERR_INSTR;
                            end
                        end else begin
                            n_stage = 1'b0;
                            s_emit  = 1'b1;
                            if (r_plen > room
                                    || (r_pact == ACT_SRC_COPY && sum_src > {1'b0, r_vlen})
                                    || (r_pact == ACT_TGT_COPY && v >= r_tpos)
                                    || (r_pact == ACT_NEW_DATA && sum_nd > {1'b0, r_ndlen}))
                            begin
                                n_phase = PH_ERROR; s_err = ERR_INSTR;
                            end else if (irem_dec == '0 && tpos_sum != r_tlen) begin
                                n_phase = PH_ERROR; s_err = ERR_TARGET;
                            end else begin
                                s_kind = KIND_INSTR;
                                n_tpos = tpos_sum;
                                if (irem_dec == '0) begin
                                    if (r_ndrem != '0) begin
                                        n_phase = PH_NEWDATA;
                                    end else begin
                                        n_phase = PH_HEADER;
                                        s_wend  = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
                default: begin
                    s_emit  = 1'b1;
                    s_kind  = KIND_DATA;
                    n_ndrem = ndrem_dec;
                    if (ndrem_dec == '0) begin
                        n_phase = PH_HEADER;
                        s_wend  = 1'b1;
                    end
                end
            endcase
        end
    end

    // record fields; fields outside the record kind stay zero
    always_comb begin
        s_rec             = '0;
        s_rec.record_kind = s_kind;
        s_rec.window_end  = s_wend;
        unique case (s_kind)
            KIND_HEADER: begin
                s_rec.src_view_offset      = lo32(r_voff);
                s_rec.src_view_length      = lo32(r_vlen);
                s_rec.tgt_view_length      = lo32(r_tlen);
                s_rec.instr_section_length = lo32(r_irem);
                s_rec.new_section_length   = lo32(s_v);
            end
            KIND_INSTR: begin
                s_rec.action    = s_act;
                s_rec.op_length = lo32(r_plen);
                s_rec.op_offset = lo32(s_v);
            end
            KIND_DATA: s_rec.data_out = b;
            KIND_ERROR: begin
                s_rec.error_code = s_err;
                s_rec.window_end = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC; r_mcnt <= '0; r_field <= '0; r_acc <= '0;
            r_first <= 1'b1; r_voff <= '0; r_vlen <= '0; r_tlen <= '0;
            r_irem <= '0; r_ndlen <= '0; r_ndrem <= '0; r_tpos <= '0;
            r_pvoff <= '0; r_pvlen <= '0; r_stage <= 1'b0; r_pact <= '0;
            r_plen <= '0; r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase; r_mcnt <= n_mcnt; r_field <= n_field;
                r_acc <= n_acc; r_first <= n_first; r_voff <= n_voff;
                r_vlen <= n_vlen; r_tlen <= n_tlen; r_irem <= n_irem;
                r_ndlen <= n_ndlen; r_ndrem <= n_ndrem; r_tpos <= n_tpos;
                r_pvoff <= n_pvoff; r_pvlen <= n_pvlen; r_stage <= n_stage;
                r_pact <= n_pact; r_plen <= n_plen;
                r_ovalid <= s_emit;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && s_emit) r_rec <= s_rec;
    end

    assign o_out.valid                = r_ovalid;
    assign o_out.record_kind          = r_rec.record_kind;
    assign o_out.action               = r_rec.action;
    assign o_out.op_length            = r_rec.op_length;
    assign o_out.op_offset            = r_rec.op_offset;
    assign o_out.data_out             = r_rec.data_out;
    assign o_out.src_view_offset      = r_rec.src_view_offset;
    assign o_out.src_view_length      = r_rec.src_view_length;
    assign o_out.tgt_view_length      = r_rec.tgt_view_length;
    assign o_out.instr_section_length = r_rec.instr_section_length;
    assign o_out.new_section_length   = r_rec.new_section_length;
    assign o_out.error_code           = r_rec.error_code;
    assign o_out.window_end           = r_rec.window_end;

endmodule

// ----- hw/rtl/delta_stream_decoder_checker_top.sv -----
// Delta stream decoder and checker: takes one stream byte (or an end mark)
// per transaction and emits at most one record per transaction: window
// headers, checked copy/insert instructions, passed-through new-data bytes,
// a clean end or a sticky error. Throughput is one byte per clock cycle,
// sustained while the output is ready; a byte goes through the two-entry
// input queue, its record through the output register; the combinational
// parser step between decodes a varint digit and runs the bound checks.
// After an error or clean end all input is consumed silently until reset.
module delta_stream_decoder_checker_top #(
    parameter int VALUE_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dsd_in_if.sink    i_in,
    dsd_out_if.source o_out
);
    import dsd_pkg::*;

    logic  q_valid, pop;
    t_item q_item;

    dsd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_pop     (pop),
        .o_q_valid (q_valid),
        .o_q_item  (q_item)
    );

    dsd_back #(.VB(VALUE_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule
